>>> hw/rtl/fletcher_checksum_engine_macros.svh
// ----------------------------------------------------------------------------
// fletcher checksum engine assertion macros
// shared concurrent assertion forms, all gated off during reset
// ----------------------------------------------------------------------------
`ifndef FLETCHER_CHECKSUM_ENGINE_MACROS_SVH
`define FLETCHER_CHECKSUM_ENGINE_MACROS_SVH

// same-cycle implication
`define FCE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fce_pkg.sv
// ----------------------------------------------------------------------------
// fce_pkg
// shared types, constants and end-around carry adders for the checksum engine
// ----------------------------------------------------------------------------
package fce_pkg;

  localparam logic [7:0]  BYTE_ONES = 8'hFF;
  localparam logic [15:0] WORD_ONES = 16'hFFFF;

  // one staged input word
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] expected_sum;
  } item_t;

  // one finished result
  typedef struct packed {
    logic [31:0] checksum_value;
    logic        sum_matches;
  } result_t;

  // ones' complement add at 8 bits, all-ones folded to zero
  function automatic logic [7:0] add8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    logic [7:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = s[7:0] + {7'b0, s[8]};
    return (f == BYTE_ONES) ? 8'h00 : f;
  endfunction

  // ones' complement add at 16 bits, all-ones folded to zero
  function automatic logic [15:0] add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [15:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = s[15:0] + {15'b0, s[16]};
    return (f == WORD_ONES) ? 16'h0000 : f;
  endfunction

endpackage

>>> hw/rtl/fce_in_stage.sv
// ----------------------------------------------------------------------------
// fce_in_stage
// input register: captures one word per cycle while in_ready is high, holds it until folded
// ----------------------------------------------------------------------------
`include "fletcher_checksum_engine_macros.svh"

module fce_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fce_pkg::item_t in_item,
  input  logic          take,
  output logic          valid,
  output fce_pkg::item_t item
);
  import fce_pkg::*;

  // free, or emptying this cycle
  assign in_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

  `FCE_ASSERT_IMPLY(a_take_needs_item, clk, rst, take, valid, "fold of an empty input register")
  `FCE_ASSERT_NEXT(a_held_when_blocked, clk, rst, valid && !take, valid && $stable(item),
    "staged word lost while blocked")

endmodule

>>> hw/rtl/fce_fold.sv
// ----------------------------------------------------------------------------
// fce_fold
// running fletcher sums, byte pairing and result formation
// ----------------------------------------------------------------------------
`include "fletcher_checksum_engine_macros.svh"

module fce_fold (
  input  logic             clk,
  input  logic             rst,
  input  logic             wide_mode,
  input  logic             step,
  input  fce_pkg::item_t   item,
  output fce_pkg::result_t result
);
  import fce_pkg::*;

  logic [15:0] low_sum, low_sum_next;
  logic [15:0] high_sum, high_sum_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        byte_pending, byte_pending_next;

  logic [15:0] word;
  logic [15:0] lo16, hi16;
  logic [7:0]  lo8, hi8;
  logic        do_word, hold;
  logic [31:0] value;

  always_comb begin
    word    = byte_pending ? {item.data_byte, held_byte} : {8'h00, item.data_byte};
    do_word = wide_mode && (byte_pending || item.last_byte);
    hold    = wide_mode && !byte_pending && !item.last_byte;

    lo16 = add16(low_sum, word);
    hi16 = add16(high_sum, lo16);
    lo8  = add8(low_sum[7:0], item.data_byte);
    hi8  = add8(high_sum[7:0], lo8);

    if (!wide_mode) begin
      low_sum_next  = {8'h00, lo8};
      high_sum_next = {8'h00, hi8};
    end else if (do_word) begin
      low_sum_next  = lo16;
      high_sum_next = hi16;
    end else begin
      low_sum_next  = low_sum;
      high_sum_next = high_sum;
    end
    held_byte_next    = hold ? item.data_byte : 8'h00;
    byte_pending_next = hold;

    // last word always completes a word in wide mode
    value = wide_mode ? {hi16, lo16} : {16'h0000, hi8, lo8};
    result.checksum_value = value;
    result.sum_matches    = (value == item.expected_sum);

    // message done: back to a clean start
    if (item.last_byte) begin
      low_sum_next      = '0;
      high_sum_next     = '0;
      held_byte_next    = '0;
      byte_pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_sum      <= '0;
      high_sum     <= '0;
      held_byte    <= '0;
      byte_pending <= 1'b0;
    end else if (step) begin
      low_sum      <= low_sum_next;
      high_sum     <= high_sum_next;
      held_byte    <= held_byte_next;
      byte_pending <= byte_pending_next;
    end
  end

  `FCE_ASSERT_NEXT(a_clear_after_last, clk, rst, step && item.last_byte,
    low_sum == 16'h0000 && high_sum == 16'h0000 && !byte_pending, "sums not cleared after last")
  `FCE_ASSERT_NEXT(a_narrow_sums, clk, rst, step && !wide_mode,
    low_sum[15:8] == 8'h00 && high_sum[15:8] == 8'h00 && !byte_pending,
    "narrow fold left wide state")

endmodule

>>> hw/rtl/fce_out_stage.sv
// ----------------------------------------------------------------------------
// fce_out_stage
// result register, decouples the fold from a stalled consumer
// ----------------------------------------------------------------------------
`include "fletcher_checksum_engine_macros.svh"

module fce_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  fce_pkg::result_t result,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output fce_pkg::result_t held
);
  import fce_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  `FCE_ASSERT_IMPLY(a_no_overwrite, clk, rst, load, free, "result overwritten before taken")

endmodule

>>> hw/rtl/fletcher_checksum_engine.sv
// ----------------------------------------------------------------------------
// fletcher_checksum_engine
// streaming fletcher-16 / fletcher-32 checksum with compare against a stored value
// ----------------------------------------------------------------------------
// Bytes of a message enter one per clock on the in_valid/in_ready channel while
// in_ready is high, the final byte marked by last_byte. Each byte is captured in
// an input register and folded into the running sums from there, so the engine
// sustains one byte per cycle unless a final byte waits; the limit is the
// combinational fold of the low sum and then the high sum, each an end-around carry
// add. Only the final byte yields a result, loaded from the input register into
// the output register once it is free, so it can be taken: checksum_value
// (high sum above low sum) and sum_matches against expected_sum. A result waiting
// in the output register does not stop plain bytes entering; only the next final
// byte waits in the input register, and in_ready stays low until the result is
// taken. wide_mode (reset 1) picks fletcher-32 over little-endian 16-bit words, an
// odd trailing byte zero-extended; 0 picks fletcher-16 over bytes. Write wide_mode
// only while no message byte is in flight.
module fletcher_checksum_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [31:0] expected_sum,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] checksum_value,
  output logic        sum_matches
);
  import fce_pkg::*;

  `include "fletcher_checksum_engine_macros.svh"

  logic    wide_mode;     // mode register
  item_t   in_item;       // word as presented on the ports
  item_t   s1_item;       // word in the input register
  logic    s1_valid;
  logic    take;          // input register folds this cycle
  logic    load;          // result register fills this cycle
  logic    out_free;
  result_t fold_result;
  result_t out_result;

  // configuration, no handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode <= 1'b1;
    end else if (cfg_we) begin
      wide_mode <= cfg_wdata;
    end
  end

  assign in_item.data_byte    = data_byte;
  assign in_item.last_byte    = last_byte;
  assign in_item.expected_sum = expected_sum;

  // input register
  fce_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .valid    (s1_valid),
    .item     (s1_item)
  );

  // a plain byte always folds; a last byte waits for room in the result register
  assign take = s1_valid && (!s1_item.last_byte || out_free);
  assign load = take && s1_item.last_byte;

  // sum update
  fce_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .wide_mode (wide_mode),
    .step      (take),
    .item      (s1_item),
    .result    (fold_result)
  );

  // result register
  fce_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .result    (fold_result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (out_result)
  );

  assign checksum_value = out_result.checksum_value;
  assign sum_matches    = out_result.sum_matches;

  `FCE_ASSERT_IMPLY(a_result_only_on_last, clk, rst, load, s1_valid && s1_item.last_byte,
    "result loaded without a last byte")
  `FCE_ASSERT_NEXT(a_last_reaches_output, clk, rst, load, out_valid,
    "last byte gave no result")
  `FCE_ASSERT_IMPLY(a_plain_byte_never_stalls, clk, rst, s1_valid && !s1_item.last_byte, take,
    "plain byte stalled in input register")

endmodule
